>>> rtl/core/huf_pkg.sv
// shared constants, types and codes of the huffman bitstream decoder
package huf_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int MAX_CODE_BITS = 32;
  localparam int WORD_BITS     = 64;

  localparam int TBL_AW  = $clog2(TABLE_DEPTH);
  localparam int ACT_W   = 9;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int SYM_W   = 8;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_LOADED   = 2'd1,
    ST_REJECTED = 2'd2,
    ST_INVALID  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_LEN = 2'd0,
    REG_SYM_TOT = 2'd1,
    REG_ENTRIES = 2'd2
  } reg_idx_t;

  localparam logic FUNC_LOAD = 1'b0;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  width;
    logic [SYM_W-1:0]  symbol;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] waddr;
    entry_t            wdata;
    logic [TBL_AW-1:0] raddr;
  } tbl_req_t;

endpackage

>>> rtl/core/huf_table_ram.sv
// code table memory, one write and one registered read port
module huf_table_ram
  import huf_pkg::*;
(
  input  logic     clk,
  input  tbl_req_t req,
  output entry_t   rdata
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> rtl/core/huffman_bitstream_decoder.sv
// top level of the bit-serial huffman bitstream decoder
// Command-style decoder: pulse start while busy is low. A load item (in_func 0) gives one
// result. A decode item consumes the 64 word bits msb first; each bit is shifted in, then
// the active table entries are scanned through the single read port of the table memory,
// one entry per cycle, ending at the first match. With no active entries no scan is made;
// active = min(table_entries, 256). After the word, a flush state drains the last result.
// An overlong code or the end of the message cuts the word short. Results appear on out_*
// for exactly one cycle under out_valid; the receiver cannot stall, and results of one
// item may come on consecutive cycles.
// cfg_ready is always high; write registers only while the block is idle.
module huffman_bitstream_decoder
  import huf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_func,
  input  logic [7:0]          in_entry_index,
  input  logic [CODE_W-1:0]   in_entry_code,
  input  logic [LEN_W-1:0]    in_entry_width,
  input  logic [SYM_W-1:0]    in_entry_symbol,
  input  logic [63:0]         in_data_word,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [SYM_W-1:0]    out_symbol,
  output logic                out_message_done,
  output logic                out_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [LEN_W-1:0]  max_len_r, max_len_nxt;
  logic [31:0]       sym_total_r, sym_total_nxt;
  logic [ACT_W-1:0]  entries_r, entries_nxt;

  // decode state
  logic [CODE_W-1:0]    pcode_r, pcode_nxt;
  logic [LEN_W-1:0]     plen_r, plen_nxt;
  logic [31:0]          count_r, count_nxt;
  logic                 finished_r, finished_nxt;
  logic                 error_r, error_nxt;
  logic                 fault_r, fault_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic [BIT_W-1:0]     bit_cnt_r, bit_cnt_nxt;
  logic                 last_bit_r, last_bit_nxt;
  logic [TBL_AW-1:0]    idx_r, idx_nxt;

  // one result held back until we know whether it is the last of the item
  logic             pend_v_r, pend_v_nxt;
  status_t          pend_st_r, pend_st_nxt;
  logic [SYM_W-1:0] pend_sym_r, pend_sym_nxt;
  logic             pend_done_r, pend_done_nxt;

  // result output registers
  logic             ov_r, ov_nxt;
  status_t          ost_r, ost_nxt;
  logic [SYM_W-1:0] osym_r, osym_nxt;
  logic             odone_r, odone_nxt;
  logic             olast_r, olast_nxt;

  tbl_req_t req;
  entry_t   rd_entry;

  huf_table_ram u_table (
    .clk   (clk),
    .req   (req),
    .rdata (rd_entry)
  );

  logic [LEN_W-1:0] limit;
  logic [ACT_W-1:0] active;
  logic [ACT_W-1:0] next_idx;
  logic [31:0]      count_inc;
  logic             hit;

  // effective code length limit and number of entries in play
  assign limit  = (max_len_r < LEN_W'(MAX_CODE_BITS)) ? max_len_r : LEN_W'(MAX_CODE_BITS);
  assign active = (entries_r > ACT_W'(TABLE_DEPTH)) ? ACT_W'(TABLE_DEPTH) : entries_r;
  assign next_idx  = ACT_W'(idx_r) + ACT_W'(1);
  assign count_inc = count_r + 32'd1;
  assign hit = (rd_entry.width == plen_r) && (rd_entry.code == pcode_r);

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_symbol       = osym_r;
  assign out_message_done = odone_r;
  assign out_last         = olast_r;

  always_comb begin
    logic             push;
    status_t          push_st;
    logic [SYM_W-1:0] push_sym;
    logic             push_done;
    logic [LEN_W-1:0] len_inc;

    state_nxt     = state_r;
    max_len_nxt   = max_len_r;
    sym_total_nxt = sym_total_r;
    entries_nxt   = entries_r;
    pcode_nxt     = pcode_r;
    plen_nxt      = plen_r;
    count_nxt     = count_r;
    finished_nxt  = finished_r;
    error_nxt     = error_r;
    fault_nxt     = fault_r;
    word_nxt      = word_r;
    bit_cnt_nxt   = bit_cnt_r;
    last_bit_nxt  = last_bit_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_st_nxt   = pend_st_r;
    pend_sym_nxt  = pend_sym_r;
    pend_done_nxt = pend_done_r;
    ov_nxt        = 1'b0;
    ost_nxt       = ost_r;
    osym_nxt      = osym_r;
    odone_nxt     = odone_r;
    olast_nxt     = olast_r;
    push          = 1'b0;
    push_st       = ST_SYMBOL;
    push_sym      = '0;
    push_done     = 1'b0;
    len_inc       = plen_r + LEN_W'(1);

    req.we        = 1'b0;
    req.waddr     = in_entry_index[TBL_AW-1:0];
    req.wdata     = '{code: in_entry_code, width: in_entry_width, symbol: in_entry_symbol};
    req.raddr     = next_idx[TBL_AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == FUNC_LOAD) begin
            // single-result load, answered straight away
            ov_nxt    = 1'b1;
            osym_nxt  = '0;
            odone_nxt = 1'b0;
            olast_nxt = 1'b1;
            if (in_entry_width > limit) begin
              fault_nxt = 1'b1;
              ost_nxt   = ST_REJECTED;
            end else begin
              req.we  = (9'(in_entry_index) < 9'(TABLE_DEPTH));
              ost_nxt = ST_LOADED;
            end
          end else if (finished_r) begin
            // message complete: word dropped silently
          end else if (fault_r || error_r) begin
            error_nxt = 1'b1;
            ov_nxt    = 1'b1;
            ost_nxt   = ST_INVALID;
            osym_nxt  = '0;
            odone_nxt = 1'b0;
            olast_nxt = 1'b1;
          end else begin
            word_nxt    = in_data_word[WORD_BITS-1:0];
            bit_cnt_nxt = '0;
            state_nxt   = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        pcode_nxt    = {pcode_r[CODE_W-2:0], word_r[WORD_BITS-1]};
        plen_nxt     = len_inc;
        word_nxt     = {word_r[WORD_BITS-2:0], 1'b0};
        bit_cnt_nxt  = bit_cnt_r + BIT_W'(1);
        last_bit_nxt = (bit_cnt_r == BIT_W'(WORD_BITS - 1));
        idx_nxt      = '0;
        req.raddr    = '0;
        if (len_inc > limit) begin
          // overlong code ends the word with a sticky error
          error_nxt = 1'b1;
          push      = 1'b1;
          push_st   = ST_INVALID;
          state_nxt = S_FLUSH;
        end else if (active == '0) begin
          state_nxt = (bit_cnt_r == BIT_W'(WORD_BITS - 1)) ? S_FLUSH : S_SHIFT;
        end else begin
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        // rd_entry holds entry idx_r; lowest index is checked first
        idx_nxt = next_idx[TBL_AW-1:0];
        if (hit) begin
          pcode_nxt = '0;
          plen_nxt  = '0;
          count_nxt = count_inc;
          push      = 1'b1;
          push_st   = ST_SYMBOL;
          push_sym  = rd_entry.symbol;
          push_done = (count_inc >= sym_total_r);
          if (count_inc >= sym_total_r) begin
            finished_nxt = 1'b1;
            state_nxt    = S_FLUSH;
          end else begin
            state_nxt = last_bit_r ? S_FLUSH : S_SHIFT;
          end
        end else if (next_idx >= active) begin
          state_nxt = last_bit_r ? S_FLUSH : S_SHIFT;
        end
      end

      S_FLUSH: begin
        if (pend_v_r) begin
          ov_nxt     = 1'b1;
          ost_nxt    = pend_st_r;
          osym_nxt   = pend_sym_r;
          odone_nxt  = pend_done_r;
          olast_nxt  = 1'b1;
          pend_v_nxt = 1'b0;
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a new result sends the held one out as not last
    if (push) begin
      if (pend_v_r) begin
        ov_nxt    = 1'b1;
        ost_nxt   = pend_st_r;
        osym_nxt  = pend_sym_r;
        odone_nxt = pend_done_r;
        olast_nxt = 1'b0;
      end
      pend_v_nxt    = 1'b1;
      pend_st_nxt   = push_st;
      pend_sym_nxt  = push_sym;
      pend_done_nxt = push_done;
    end

    // register writes
    if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_LEN: begin
          max_len_nxt = cfg_data[LEN_W-1:0];
        end
        REG_SYM_TOT: begin
          sym_total_nxt = cfg_data;
          pcode_nxt     = '0;
          plen_nxt      = '0;
          count_nxt     = '0;
          finished_nxt  = 1'b0;
          error_nxt     = 1'b0;
        end
        REG_ENTRIES: begin
          entries_nxt = cfg_data[ACT_W-1:0];
          fault_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      max_len_r   <= LEN_W'(32);
      sym_total_r <= 32'd1;
      entries_r   <= '0;
      pcode_r     <= '0;
      plen_r      <= '0;
      count_r     <= '0;
      finished_r  <= 1'b0;
      error_r     <= 1'b0;
      fault_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      max_len_r   <= max_len_nxt;
      sym_total_r <= sym_total_nxt;
      entries_r   <= entries_nxt;
      pcode_r     <= pcode_nxt;
      plen_r      <= plen_nxt;
      count_r     <= count_nxt;
      finished_r  <= finished_nxt;
      error_r     <= error_nxt;
      fault_r     <= fault_nxt;
      pend_v_r    <= pend_v_nxt;
      ov_r        <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    last_bit_r  <= last_bit_nxt;
    idx_r       <= idx_nxt;
    pend_st_r   <= pend_st_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_done_r <= pend_done_nxt;
    ost_r       <= ost_nxt;
    osym_r      <= osym_nxt;
    odone_r     <= odone_nxt;
    olast_r     <= olast_nxt;
  end

endmodule

>>> tb/huf_scoreboard.sv
// scoreboard class: predicts the decoder results and checks the observed ones
`timescale 1ns / 100ps

import huf_pkg::*;

class huf_scoreboard;

  typedef struct {
    status_t    status;
    logic [7:0] symbol;
    logic       done;
    logic       last;
  } result_t;

  logic [31:0] code_mem [TABLE_DEPTH];
  logic [5:0]  width_mem [TABLE_DEPTH];
  logic [7:0]  symbol_mem [TABLE_DEPTH];
  logic [31:0] part_code;
  logic [5:0]  part_len;
  logic [31:0] sym_count;
  logic        finished;
  logic        sticky_err;
  logic        tbl_fault;
  logic [5:0]  max_len;
  logic [31:0] sym_total;
  logic [8:0]  n_entries;
  result_t     expected_q [$];
  int          fails;

  function new();
    part_code  = '0;
    part_len   = '0;
    sym_count  = '0;
    finished   = 1'b0;
    sticky_err = 1'b0;
    tbl_fault  = 1'b0;
    max_len    = 6'd32;
    sym_total  = 32'd1;
    n_entries  = '0;
    fails      = 0;
  endfunction

  function int code_limit();
    return (max_len < MAX_CODE_BITS) ? int'(max_len) : MAX_CODE_BITS;
  endfunction

  function void write_reg(reg_idx_t idx, logic [31:0] data);
    case (idx)
      REG_MAX_LEN: max_len = data[5:0];
      REG_SYM_TOT: begin
        sym_total  = data;
        part_code  = '0;
        part_len   = '0;
        sym_count  = '0;
        finished   = 1'b0;
        sticky_err = 1'b0;
      end
      REG_ENTRIES: begin
        n_entries = data[8:0];
        tbl_fault = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // works out the results of one accepted item and queues them
  function void note_item(logic func, logic [7:0] idx, logic [31:0] code, logic [5:0] width,
                          logic [7:0] sym, logic [63:0] word);
    result_t res [$];
    result_t r;
    int      lim;
    int      act;
    int      hit;
    lim = code_limit();
    r.symbol = '0;
    r.done   = 1'b0;
    r.last   = 1'b0;
    if (func == FUNC_LOAD) begin
      if (int'(width) > lim) begin
        tbl_fault = 1'b1;
        r.status  = ST_REJECTED;
      end else begin
        code_mem[idx]   = code;
        width_mem[idx]  = width;
        symbol_mem[idx] = sym;
        r.status        = ST_LOADED;
      end
      res.insert(res.size(), r);
    end else begin
      act = (n_entries < TABLE_DEPTH) ? int'(n_entries) : TABLE_DEPTH;
      if (finished) return;
      if (tbl_fault || sticky_err) begin
        sticky_err = 1'b1;
        r.status   = ST_INVALID;
        res.insert(res.size(), r);
      end else begin
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
          part_code = {part_code[30:0], word[i]};
          part_len  = part_len + 6'd1;
          if (int'(part_len) > lim) begin
            sticky_err = 1'b1;
            r.status   = ST_INVALID;
            r.symbol   = '0;
            r.done     = 1'b0;
            res.insert(res.size(), r);
            break;
          end
          hit = -1;
          for (int e = 0; e < act; e++) begin
            if (width_mem[e] == part_len && code_mem[e] == part_code) begin
              hit = e;
              break;
            end
          end
          if (hit >= 0) begin
            part_code = '0;
            part_len  = '0;
            sym_count = sym_count + 32'd1;
            r.status  = ST_SYMBOL;
            r.symbol  = symbol_mem[hit];
            r.done    = (sym_count >= sym_total);
            res.insert(res.size(), r);
            if (r.done) begin
              finished = 1'b1;
              break;
            end
          end
        end
      end
    end
    if (res.size() == 0) return;
    res[res.size()-1].last = 1'b1;
    foreach (res[k]) expected_q.insert(expected_q.size(), res[k]);
  endfunction

  function void check(logic [1:0] status, logic [7:0] symbol, logic done, logic last);
    result_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: status %0d symbol %0h", status, symbol);
      fails++;
      return;
    end
    e = expected_q.pop_front();
    if (status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, status);
      fails++;
    end
    if (symbol !== e.symbol) begin
      $error("symbol: expected %0h, actual %0h", e.symbol, symbol);
      fails++;
    end
    if (done !== e.done) begin
      $error("message_done: expected %0b, actual %0b", e.done, done);
      fails++;
    end
    if (last !== e.last) begin
      $error("last: expected %0b, actual %0b", e.last, last);
      fails++;
    end
  endfunction
endclass

>>> tb/tb_huffman_bitstream_decoder.sv
// top level testbench of the huffman bitstream decoder
`timescale 1ns / 100ps

module tb_huffman_bitstream_decoder;
  import huf_pkg::*;

  // cycles with no transfer at all before the run is declared hung; a word may scan the whole
  // table for each of its bits with no result
  localparam int STALL_LIMIT = 60000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = 1'b0;
  logic [7:0]  in_entry_index = '0;
  logic [31:0] in_entry_code = '0;
  logic [5:0]  in_entry_width = '0;
  logic [7:0]  in_entry_symbol = '0;
  logic [63:0] in_data_word = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [7:0]  out_symbol;
  logic        out_message_done;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  huf_scoreboard decode_sb = new();

  int burst_left = 0;
  bit no_gaps = 1'b0;
  int quiet_cycles = 0;

  // code table of the current phase
  logic [31:0] tbl_code [TABLE_DEPTH];
  logic [5:0]  tbl_width [TABLE_DEPTH];
  int          tbl_size;

  always #2 clk = ~clk;

  huffman_bitstream_decoder i_dut (.*);

  // results cannot be held off, so every strobe is a transfer
  always @(posedge clk) begin
    if (rst_n && out_valid)
      decode_sb.check(out_status, out_symbol, out_message_done, out_last);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one item, with the sender idling between bursts unless no_gaps is set
  task automatic send_item(logic func, logic [7:0] idx, logic [31:0] code,
                           logic [5:0] width, logic [7:0] sym, logic [63:0] word);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = no_gaps ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = func;
    in_entry_index = idx;
    in_entry_code = code;
    in_entry_width = width;
    in_entry_symbol = sym;
    in_data_word = word;
    start = 1'b1;
    do @(posedge clk); while (busy);
    decode_sb.note_item(func, idx, code, width, sym, word);
    @(negedge clk);
  endtask

  task automatic load(logic [7:0] idx, logic [31:0] code, logic [5:0] width, logic [7:0] sym);
    send_item(FUNC_LOAD, idx, code, width, sym, {$urandom, $urandom});
  endtask

  task automatic decode(logic [63:0] word);
    send_item(~FUNC_LOAD, 8'($urandom), 32'($urandom), 6'($urandom), 8'($urandom), word);
  endtask

  // drain: all expected results in and the block no longer busy
  task automatic wait_idle();
    start = 1'b0;
    repeat (2) @(negedge clk);
    while (decode_sb.expected_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    decode_sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random complete prefix code: repeatedly split a leaf that is still short enough
  task automatic build_code(int n_leaves, int lim);
    int pick;
    int tries;
    tbl_code[0] = '0;
    tbl_width[0] = '0;
    tbl_size = 1;
    while (tbl_size < n_leaves) begin
      tries = 0;
      do begin
        pick = $urandom_range(0, tbl_size - 1);
        tries++;
      end while (int'(tbl_width[pick]) >= lim && tries < 200);
      if (int'(tbl_width[pick]) >= lim) break;
      tbl_code[tbl_size] = {tbl_code[pick][30:0], 1'b1};
      tbl_width[tbl_size] = tbl_width[pick] + 6'd1;
      tbl_code[pick] = {tbl_code[pick][30:0], 1'b0};
      tbl_width[pick] = tbl_width[pick] + 6'd1;
      tbl_size++;
    end
  endtask

  // one setting of the block: table, registers, then a run of words
  task automatic run_phase(logic [5:0] max_len, int n_leaves, logic [8:0] entries_reg,
                           logic [31:0] total, int n_words);
    int lim;
    int k;
    lim = (max_len < 32) ? int'(max_len) : 32;
    wait_idle();
    write_reg(REG_MAX_LEN, 32'(max_len));
    build_code(n_leaves, lim);
    // noise: a stray high bit breaks completeness, so overlong codes show up
    if (tbl_size > 1 && $urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, tbl_size - 1);
      if (tbl_width[k] < 32) tbl_code[k][tbl_width[k]] = 1'b1;
    end
    // duplicates behind the originals and an empty entry, none of which can win
    if (tbl_size < TABLE_DEPTH - 3 && $urandom_range(0, 1) == 1) begin
      k = $urandom_range(0, tbl_size - 1);
      tbl_code[tbl_size] = tbl_code[k];
      tbl_width[tbl_size] = tbl_width[k];
      tbl_size++;
      tbl_code[tbl_size] = $urandom;
      tbl_width[tbl_size] = '0;
      tbl_size++;
    end
    for (int i = 0; i < tbl_size; i++) load(8'(i), tbl_code[i], tbl_width[i], 8'($urandom));
    wait_idle();
    if (entries_reg == '1 || entries_reg > tbl_size) entries_reg = entries_reg;
    else entries_reg = 9'(tbl_size);
    write_reg(REG_ENTRIES, 32'(entries_reg));
    write_reg(REG_SYM_TOT, total);
    // an entry too wide for the limit poisons the table for later words
    if (lim < 63 && $urandom_range(0, 4) == 0)
      load(8'($urandom_range(tbl_size, 255)), $urandom, 6'($urandom_range(lim + 1, 63)),
           8'($urandom));
    for (int w = 0; w < n_words; w++) begin
      case ($urandom_range(0, 9))
        0: decode('0);
        1: decode('1);
        default: decode({$urandom, $urandom});
      endcase
      if (w == n_words / 2 && $urandom_range(0, 3) == 0) begin
        wait_idle();
        write_reg(REG_SYM_TOT, $urandom_range(1, 80));
      end
    end
  endtask

  initial begin
    logic [5:0] lens [4];
    lens = '{6'd4, 6'd8, 6'd16, 6'd32};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: table extremes, rejected widths, duplicate and empty entries
    no_gaps = 1'b1;
    load(8'd0, 32'h0, 6'd1, 8'h41);
    load(8'd1, 32'h2, 6'd2, 8'h42);
    load(8'd2, 32'h6, 6'd3, 8'h43);
    load(8'd3, 32'h7, 6'd3, 8'h00);
    load(8'd4, 32'h0, 6'd1, 8'hee);
    load(8'd5, 32'h0, 6'd0, 8'h55);
    load(8'd6, 32'h5, 6'd2, 8'h66);
    load(8'd255, 32'hffff_ffff, 6'd32, 8'hff);
    load(8'd7, 32'h1, 6'd33, 8'h01);
    load(8'd7, 32'hffff_ffff, 6'd63, 8'hff);
    decode(64'h0123_4567_89ab_cdef);
    wait_idle();
    write_reg(REG_ENTRIES, 32'd7);
    write_reg(REG_SYM_TOT, 32'd0);
    decode(64'hdead_beef_0000_ffff);
    decode(64'h8000_0000_0000_0001);
    wait_idle();
    write_reg(REG_SYM_TOT, 32'hffff_ffff);
    decode('0);
    decode('1);
    decode(64'h5555_aaaa_5555_aaaa);
    decode(64'hffff_ffff_ffff_fffe);
    wait_idle();
    write_reg(REG_MAX_LEN, 32'd1);
    decode(64'h4000_0000_0000_0000);
    decode('0);
    no_gaps = 1'b0;

    // register extremes
    run_phase(6'd63, 5, 9'd0, 32'd3, 4);
    run_phase(6'd1, 2, 9'd0, 32'd1, 6);
    run_phase(6'd32, 256, 9'h1ff, 32'd40, 3);
    run_phase(6'd0, 1, 9'd0, 32'd5, 3);

    // random settings, mostly small tables
    for (int p = 0; p < 10; p++) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      run_phase(($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) :
                lens[$urandom_range(0, 3)],
                $urandom_range(1, 12), 9'd0,
                ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 100),
                $urandom_range(8, 20));
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (decode_sb.fails == 0 && decode_sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> huffman_bitstream_decoder.f
rtl/core/huf_pkg.sv
rtl/core/huf_table_ram.sv
rtl/core/huffman_bitstream_decoder.sv
tb/huf_scoreboard.sv
tb/tb_huffman_bitstream_decoder.sv
